@@ design/gcpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gcpu_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int PLANE_W     = 8;
   localparam int PHASE_W     = 16;
   localparam int ORDER_W     = 8;
   localparam int ABS_OUT_W   = 24;

   localparam logic [PLANE_W-1:0] THRESHOLD_RESET = 8'd80;

   // pi and 2pi in Q32
   localparam logic [35:0] PI_Q32     = 36'h3243F6A88;
   localparam logic [35:0] TWO_PI_Q32 = 36'h6487ED511;

   typedef logic [PLANE_COUNT-1:0][PLANE_W-1:0] plane_array_type;

   typedef enum logic [1:0] {
      ADJ_NONE  = 2'd0,
      ADJ_RAISE = 2'd1,
      ADJ_LOWER = 2'd2
   } adjust_type;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
      adjust_type         adjust;
   } order_result_type;

endpackage

`default_nettype wire

@@ design/gray_code_phase_unwrap_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake                    payload
// req      in   req_tvalid / req_tready      tdata: planes 0..5, wrapped phase; tuser: row start
// rsp      out  rsp_tvalid / rsp_tready      tdata: absolute phase, order; tuser: adjustment
// csr      in   csr_wr_en (no wait)          csr_wr_data: binarize threshold
//
// One pixel per cycle sustained while rsp_tready stays high; a low rsp_tready stalls the stages.
// The rate is set by the order feedback: previous raw phase and order update with each pixel.
// Stages: input register, decode and raw multiply, order correction, output multiply.
// Each stage loads when it is empty or the next one moves, so bubbles close under stall.
// Synchronous reset clears valids, the threshold (to 80) and the row tracking state.

module gray_code_phase_unwrap_top #(
   parameter int GRAY_BITS       = 6,
   parameter int PHASE_FRAC_BITS = 13
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // gray_plane_0..gray_plane_5, wrapped phase
   input  wire logic [0:0]  req_tuser,   // row_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // absolute_phase, phase_order
   output logic [1:0]       rsp_tuser,   // adjustment
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   localparam int         SHIFT      = 32 - PHASE_FRAC_BITS;
   localparam logic [63:0] ROUND     = 64'd1 << (SHIFT - 1);
   localparam logic [63:0] PI_VAL    = (64'(gcpu_pkg::PI_Q32) + ROUND) >> SHIFT;
   localparam logic [63:0] TWO_PI_VAL = (64'(gcpu_pkg::TWO_PI_Q32) + ROUND) >> SHIFT;
   localparam logic [63:0] PHASE_MAX = (64'd1 << gcpu_pkg::PHASE_W) - 64'd1;
   localparam logic [63:0] RAW_MAX   =
      ((64'd1 << GRAY_BITS) - 64'd1) * TWO_PI_VAL + PHASE_MAX;
   localparam logic [63:0] ABS_MAX   =
      ((64'd1 << gcpu_pkg::ORDER_W) - 64'd1) * TWO_PI_VAL + PHASE_MAX;
   localparam int         RAW_W      = $clog2(RAW_MAX + 64'd1);
   localparam int         ABS_W      = $clog2(ABS_MAX + 64'd1);
   localparam logic [RAW_W-1:0] PI_RAW     = RAW_W'(PI_VAL);
   localparam logic [RAW_W-1:0] TWO_PI_RAW = RAW_W'(TWO_PI_VAL);
   localparam logic [ABS_W-1:0] TWO_PI_ABS = ABS_W'(TWO_PI_VAL);

   localparam int PLANE_BITS = gcpu_pkg::PLANE_COUNT * gcpu_pkg::PLANE_W;

   logic [gcpu_pkg::PLANE_W-1:0]   threshold_ff;

   logic                           s1_valid_ff;
   logic                           s1_row_ff;
   gcpu_pkg::plane_array_type      s1_planes_ff;
   logic [gcpu_pkg::PHASE_W-1:0]   s1_theta_ff;

   logic                           s2_valid_ff;
   logic                           s2_row_ff;
   logic [GRAY_BITS-1:0]           s2_k_ff;
   logic [RAW_W-1:0]               s2_raw_ff;
   logic [gcpu_pkg::PHASE_W-1:0]   s2_theta_ff;

   logic                           s3_valid_ff;
   gcpu_pkg::order_result_type     s3_result_ff;
   logic [gcpu_pkg::PHASE_W-1:0]   s3_theta_ff;

   logic                           out_valid_ff;
   logic [gcpu_pkg::ABS_OUT_W-1:0] out_abs_ff;
   logic [gcpu_pkg::ORDER_W-1:0]   out_order_ff;
   gcpu_pkg::adjust_type           out_adjust_ff;

   logic                           out_ready;
   logic                           s3_ready;
   logic                           s2_ready;
   logic                           s1_ready;
   logic [GRAY_BITS-1:0]           k_in;
   logic [RAW_W-1:0]               raw_in;
   gcpu_pkg::order_result_type     result_in;
   logic [ABS_W-1:0]               abs_in;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s3_ready   = !s3_valid_ff || out_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= gcpu_pkg::THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && s1_ready) begin
         s1_row_ff    <= req_tuser[0];
         s1_planes_ff <= req_tdata[PLANE_BITS-1:0];
         s1_theta_ff  <= req_tdata[PLANE_BITS +: gcpu_pkg::PHASE_W];
      end
   end

   gcpu_decode #(
      .GRAY_BITS (GRAY_BITS)
   ) u_decode (
      .planes    (s1_planes_ff),
      .threshold (threshold_ff),
      .order     (k_in)
   );

   assign raw_in = RAW_W'(k_in) * TWO_PI_RAW + RAW_W'(s1_theta_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_row_ff   <= s1_row_ff;
         s2_k_ff     <= k_in;
         s2_raw_ff   <= raw_in;
         s2_theta_ff <= s1_theta_ff;
      end
   end

   gcpu_order_track #(
      .GRAY_BITS (GRAY_BITS),
      .RAW_W     (RAW_W),
      .PI_FIX    (PI_RAW)
   ) u_order_track (
      .clock     (clock),
      .reset     (reset),
      .commit    (s2_valid_ff && s3_ready),
      .row_start (s2_row_ff),
      .k_raw     (s2_k_ff),
      .raw       (s2_raw_ff),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_ready) begin
         s3_result_ff <= result_in;
         s3_theta_ff  <= s2_theta_ff;
      end
   end

   assign abs_in = ABS_W'(s3_result_ff.order) * TWO_PI_ABS + ABS_W'(s3_theta_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && out_ready) begin
         out_abs_ff    <= gcpu_pkg::ABS_OUT_W'(abs_in);
         out_order_ff  <= s3_result_ff.order;
         out_adjust_ff <= s3_result_ff.adjust;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_order_ff, out_abs_ff};
   assign rsp_tuser  = out_adjust_ff;

endmodule

`default_nettype wire

@@ design/gcpu_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcpu_decode #(
   parameter int GRAY_BITS = 6
) (
   input  wire gcpu_pkg::plane_array_type        planes,
   input  wire logic [gcpu_pkg::PLANE_W-1:0]     threshold,
   output logic [GRAY_BITS-1:0]                  order
);

   logic [7:0][gcpu_pkg::PLANE_W-1:0] planes_ext;
   logic                              acc;

   // planes past the sixth read as zero
   assign planes_ext = (8 * gcpu_pkg::PLANE_W)'(planes);

   always_comb begin
      acc   = 1'b0;
      order = '0;
      for (int i = 0; i < GRAY_BITS; i++) begin
         acc = acc ^ (planes_ext[i] > threshold);
         order[GRAY_BITS-1-i] = acc;
      end
   end

endmodule

`default_nettype wire

@@ design/gcpu_order_track.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcpu_order_track #(
   parameter int               GRAY_BITS = 6,
   parameter int               RAW_W     = 22,
   parameter logic [RAW_W-1:0] PI_FIX    = 22'd25736
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               commit,
   input  wire logic                               row_start,
   input  wire logic [GRAY_BITS-1:0]               k_raw,
   input  wire logic [RAW_W-1:0]                   raw,
   output gcpu_pkg::order_result_type              result
);

   localparam logic [1:0] COL_FULL = 2'd2;

   logic [1:0]                    column_count_ff;
   logic [1:0]                    column_count_in;
   logic [RAW_W-1:0]              prev_raw_ff;
   logic [gcpu_pkg::ORDER_W-1:0]  prev_order_ff;
   logic [1:0]                    col_eff;
   logic                          big_jump;
   logic [gcpu_pkg::ORDER_W:0]    k_ext;
   logic [gcpu_pkg::ORDER_W:0]    prev_ext;

   always_comb begin
      col_eff  = row_start ? 2'd0 : column_count_ff;
      big_jump = ({1'b0, raw} >= ({1'b0, prev_raw_ff} + {1'b0, PI_FIX}));
      k_ext    = (gcpu_pkg::ORDER_W + 1)'(k_raw);
      prev_ext = {1'b0, prev_order_ff};
      result.order  = gcpu_pkg::ORDER_W'(k_raw);
      result.adjust = gcpu_pkg::ADJ_NONE;
      if (col_eff == COL_FULL) begin
         if (big_jump && (k_ext == prev_ext)) begin
            result.order  = prev_order_ff + 8'd1;
            result.adjust = gcpu_pkg::ADJ_RAISE;
         end else if (!big_jump && (k_ext == prev_ext + 9'd1)) begin
            // no wrap on the compare: order 255 never lowers
            result.order  = prev_order_ff;
            result.adjust = gcpu_pkg::ADJ_LOWER;
         end
      end
      column_count_in = (col_eff == COL_FULL) ? col_eff : col_eff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 2'd0;
         prev_raw_ff     <= '0;
         prev_order_ff   <= '0;
      end else if (commit) begin
         column_count_ff <= column_count_in;
         prev_raw_ff     <= raw;
         prev_order_ff   <= result.order;
      end
   end

endmodule

`default_nettype wire

@@ design/gcpu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcpu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // with the output draining, rsp_tvalid follows once the request has passed the pipeline registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("result missing after fixed latency");

   // first pixel of a row is never adjusted
   a_row_start_plain: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0]) ##1 rsp_tready ##1 rsp_tready
      ##1 rsp_tready |=> rsp_tuser == 2'(gcpu_pkg::ADJ_NONE))
      else $error("row start pixel adjusted");

endmodule

bind gray_code_phase_unwrap_top gcpu_checker u_gcpu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ bench/tb_gray_code_phase_unwrap_top.sv @@
`timescale 1ns / 1ps

module tb_gray_code_phase_unwrap_top;

   localparam int          FRAC_BITS       = 13;
   localparam int unsigned PI_FIX          =
      int'((gcpu_pkg::PI_Q32 + (36'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
   localparam int unsigned TWO_PI_FIX      =
      int'((gcpu_pkg::TWO_PI_Q32 + (36'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
   localparam int          ITEMS_PER_PHASE = 300;
   localparam int          STALL_AT        = 400;
   localparam int          STALL_CYCLES    = 300;
   localparam int          CYCLE_LIMIT     = 200000;

   typedef struct packed {
      logic [23:0]          abs_phase;
      logic [7:0]           order;
      gcpu_pkg::adjust_type adjust;
   } unwrap_type;

   typedef struct {
      logic                      row_start;
      gcpu_pkg::plane_array_type planes;
      logic [15:0]               phase;
      bit                        known;
      unwrap_type                typed;
   } pixel_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // gray_plane_0..gray_plane_5, wrapped phase
   logic [0:0]  req_tuser;   // row_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;   // absolute_phase, phase_order
   logic [1:0]  rsp_tuser;   // adjustment
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   // predictor state
   logic [7:0]  thr_model        = gcpu_pkg::THRESHOLD_RESET;
   logic [1:0]  col_model        = 2'd0;
   logic [21:0] prev_raw_model   = 22'd0;
   logic [7:0]  prev_order_model = 8'd0;

   unwrap_type  phase_due[$];
   pixel_type   bench_rows[$];
   int          fault_count = 0;
   int          rsp_seen    = 0;
   int          hold_left   = 0;
   bit          stall_done  = 1'b0;
   bit          calm        = 1'b0;
   int          cycle_count = 0;

   gray_code_phase_unwrap_top #(
      .GRAY_BITS      (6),
      .PHASE_FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic unwrap_type unwrap_pixel(pixel_type px);
      unwrap_type  res;
      logic        gray_acc;
      int unsigned k;
      logic [21:0] raw;
      logic        big_jump;
      int          i;
      gray_acc = 1'b0;
      k = 0;
      for (i = 0; i < gcpu_pkg::PLANE_COUNT; i++) begin
         gray_acc = gray_acc ^ (px.planes[i] > thr_model);
         k = (k << 1) | gray_acc;
      end
      raw = 22'(k * TWO_PI_FIX + px.phase);
      res.adjust = gcpu_pkg::ADJ_NONE;
      if (px.row_start) begin
         col_model = 2'd0;
      end
      if (col_model == 2'd2) begin
         big_jump = (raw >= prev_raw_model) && (raw - prev_raw_model >= PI_FIX);
         if (big_jump && k == prev_order_model) begin
            k = (prev_order_model + 32'd1) & 32'hFF;
            res.adjust = gcpu_pkg::ADJ_RAISE;
         end else if (!big_jump && k == prev_order_model + 32'd1) begin
            k = prev_order_model;
            res.adjust = gcpu_pkg::ADJ_LOWER;
         end
      end
      prev_raw_model = raw;
      prev_order_model = 8'(k);
      if (col_model != 2'd2) begin
         col_model = col_model + 2'd1;
      end
      res.abs_phase = 24'(k * TWO_PI_FIX + px.phase);
      res.order = 8'(k);
      return res;
   endfunction

   // plane intensities that binarize to the Gray code of order k
   function automatic gcpu_pkg::plane_array_type planes_for_order(int unsigned k);
      gcpu_pkg::plane_array_type pl;
      logic [5:0]                gray;
      int                        i;
      gray = 6'(k ^ (k >> 1));
      for (i = 0; i < gcpu_pkg::PLANE_COUNT; i++) begin
         if (gray[gcpu_pkg::PLANE_COUNT-1-i]) begin
            pl[i] = (thr_model == 8'hFF) ? 8'hFF : 8'($urandom_range(255, thr_model + 1));
         end else begin
            pl[i] = 8'($urandom_range(thr_model, 0));
         end
      end
      return pl;
   endfunction

   task automatic add_row(input logic rs, input logic [47:0] planes, input logic [15:0] phase,
                          input bit known, input logic [23:0] abs_phase,
                          input logic [7:0] order, input gcpu_pkg::adjust_type adjust);
      pixel_type px;
      px.row_start = rs;
      px.planes = planes;
      px.phase = phase;
      px.known = known;
      px.typed.abs_phase = abs_phase;
      px.typed.order = order;
      px.typed.adjust = adjust;
      bench_rows.insert(bench_rows.size(), px);
   endtask

   task automatic send_pixel(pixel_type px);
      unwrap_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= {px.phase, px.planes};
      req_tuser  <= px.row_start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = unwrap_pixel(px);
      if (px.known) begin
         predicted = px.typed;
      end
      phase_due.insert(phase_due.size(), predicted);
      while (!calm && ($urandom_range(99) < 19)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // a smooth phase ramp along a row, with order slips, wild theta and noise
   task automatic send_row(int unsigned len);
      pixel_type   px;
      int unsigned pos;
      int unsigned step;
      int unsigned k;
      int unsigned pick;
      int unsigned n;
      pos = $urandom_range(40 * TWO_PI_FIX, 0);
      step = $urandom_range(20000, 0);
      px.known = 1'b0;
      px.typed = '0;
      for (n = 0; n < len; n++) begin
         pick = $urandom_range(99);
         k = pos / TWO_PI_FIX;
         if (pick < 8 && k < 63) begin
            k++;
         end else if (pick < 16 && k > 0) begin
            k--;
         end
         if (k > 63) begin
            k = 63;
         end
         px.row_start = (n == 0) && ($urandom_range(19) != 0);
         px.planes = planes_for_order(k);
         if (pick >= 16 && pick < 20) begin
            px.phase = 16'($urandom_range(65535, TWO_PI_FIX));
         end else begin
            px.phase = 16'(pos % TWO_PI_FIX);
         end
         if (pick >= 95) begin
            px.row_start = 1'($urandom_range(1));
            px.planes = 48'({$urandom, $urandom});
            px.phase = 16'($urandom);
         end
         send_pixel(px);
         pos += step;
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (phase_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(logic [7:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      thr_model = value;
   endtask

   task automatic check_result();
      unwrap_type want;
      rsp_seen++;
      if (phase_due.size() == 0) begin
         $error("result with no pixel pending: tdata %h tuser %h", rsp_tdata, rsp_tuser);
         fault_count++;
      end else begin
         want = phase_due.pop_front();
         if (rsp_tdata[23:0] !== want.abs_phase) begin
            $error("absolute_phase expected %0d actual %0d", want.abs_phase, rsp_tdata[23:0]);
            fault_count++;
         end
         if (rsp_tdata[31:24] !== want.order) begin
            $error("phase_order expected %0d actual %0d", want.order, rsp_tdata[31:24]);
            fault_count++;
         end
         if (rsp_tuser !== want.adjust) begin
            $error("adjustment expected %0d actual %0d", want.adjust, rsp_tuser);
            fault_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (!stall_done && rsp_seen >= STALL_AT) begin
            stall_done <= 1'b1;
            hold_left  <= STALL_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 19);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("gray_code_phase_unwrap_top verification failed");
         $finish;
      end
   end

   initial begin
      logic [7:0]  thr;
      int unsigned len;
      int          sent;
      int          ph;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;

      // threshold at reset value; no row start seen yet
      add_row(1'b0, 48'h0000_0000_0000, 16'd0,     1'b1, 24'd0,       8'd0,
              gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'hFFFF_FFFF_FFFF, 16'd51471, 1'b1, 24'd2213295, 8'd42,
              gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'h0000_0000_0000, 16'd0,     1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      // jump of exactly pi raises
      add_row(1'b1, 48'h0000_0000_0000, 16'd0,     1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'h0000_0000_0000, 16'd0,     1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'h0000_0000_0000, 16'd25735, 1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'h0000_0000_0000, 16'd51471, 1'b1, 24'd102943,  8'd1,
              gcpu_pkg::ADJ_RAISE);
      // small jump into next order lowers
      add_row(1'b1, 48'h0000_0000_0000, 16'd0,     1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'h0000_0000_0000, 16'd20000, 1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'h0000_0000_0000, 16'd40000, 1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'hC800_0000_0000, 16'd0,     1'b1, 24'd0,       8'd0,
              gcpu_pkg::ADJ_LOWER);
      // plane equal to threshold reads zero, one above reads one; theta past 2pi
      add_row(1'b1, 48'h5050_5050_5050, 16'd65535, 1'b1, 24'd65535,   8'd0,
              gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'h5151_5151_5151, 16'd0,     1'b1, 24'd2161824, 8'd42,
              gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'h5151_5151_5151, 16'd65535, 1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      add_row(1'b1, 48'h00FF_00FF_00FF, 16'd12345, 1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'h0000_0000_00FF, 16'h5555,  1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'hFF00_0000_0000, 16'hAAAA,  1'b0, '0, '0, gcpu_pkg::ADJ_NONE);
      add_row(1'b0, 48'hFF00_0000_0000, 16'hFFFF,  1'b0, '0, '0, gcpu_pkg::ADJ_NONE);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (bench_rows[n]) begin
         send_pixel(bench_rows[n]);
      end

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: thr = 8'd0;
            1: thr = 8'd255;
            5: thr = gcpu_pkg::THRESHOLD_RESET;
            default: thr = 8'($urandom_range(254, 1));
         endcase
         write_threshold(thr);
         calm <= (ph == 3);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(40, 3);
            send_row(len);
            sent += len;
         end
      end

      wait_idle();
      if (fault_count == 0) begin
         $display("gray_code_phase_unwrap_top verification clean");
      end else begin
         $display("gray_code_phase_unwrap_top verification failed");
      end
      $finish;
   end

endmodule
